[rtl/pa3d_pkg.sv]
package pa3d_pkg;

    // Fixed field widths
    localparam int IN_BITS    = 16;
    localparam int SUM_BITS   = 44;
    localparam int OUT_BITS   = 43;
    localparam int HALF_BITS  = 22;
    localparam int ROOT_BITS  = 46;
    localparam int SQ_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;

    // Job queue between front and back (power of two, pointers wrap naturally)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Result status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_FEW = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;

    typedef struct packed {
        logic signed [IN_BITS-1:0] vx;
        logic signed [IN_BITS-1:0] vy;
        logic signed [IN_BITS-1:0] vz;
        logic                      last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] twice_area;
        logic [1:0]          status;
    } result_t;

    // One finished polygon: summed cross vector and its status
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_x;
        logic signed [SUM_BITS-1:0] sum_y;
        logic signed [SUM_BITS-1:0] sum_z;
        logic [1:0]                 status;
    } job_t;

endpackage

[rtl/pa3d_fifo.sv]
module pa3d_fifo
    import pa3d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output job_t rdata,
    output logic empty
);

    job_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wptr_reg;
    logic [QPTR_BITS-1:0] rptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/pa3d_front.sv]
module pa3d_front
    import pa3d_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  vertex_t s_data,
    output logic    q_push,
    input  logic    q_full,
    output job_t    q_data
);

    localparam int CW    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} fstate_t;

    fstate_t                    state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       ovf_reg;
    logic                       last_reg;
    logic                       acc_en_reg;
    logic                       close_reg;
    logic [1:0]                 status_reg;
    logic signed [CW-1:0]       first_reg [3];
    logic signed [CW-1:0]       prev_reg  [3];
    logic signed [CW-1:0]       a_reg     [3];
    logic signed [CW-1:0]       b_reg     [3];
    logic signed [2*CW-1:0]     p_reg     [6];
    logic signed [SUM_BITS-1:0] sum_reg   [3];

    logic [31:0]                ext [3];
    logic signed [CW-1:0]       cur [3];
    logic signed [SUM_BITS-1:0] term [3];
    logic                       dup;
    logic [1:0]                 status_c;

    // take the low coordinate bits, sign from the top one
    always_comb begin
        ext[0] = {{(32-IN_BITS){1'b0}}, s_data.vx};
        ext[1] = {{(32-IN_BITS){1'b0}}, s_data.vy};
        ext[2] = {{(32-IN_BITS){1'b0}}, s_data.vz};
        for (int i = 0; i < 3; i++) begin
            cur[i] = signed'(ext[i][CW-1:0]);
        end
    end

    // cross product terms from registered products
    always_comb begin
        term[0] = SUM_BITS'(p_reg[0]) - SUM_BITS'(p_reg[1]);
        term[1] = SUM_BITS'(p_reg[2]) - SUM_BITS'(p_reg[3]);
        term[2] = SUM_BITS'(p_reg[4]) - SUM_BITS'(p_reg[5]);
    end

    // status of a finished polygon; a repeated closing vertex is not counted
    always_comb begin
        dup = (cnt_reg >= CNT_W'(2)) && (prev_reg[0] == first_reg[0]) &&
              (prev_reg[1] == first_reg[1]) && (prev_reg[2] == first_reg[2]);
        if (ovf_reg) begin
            status_c = STATUS_OVF;
        end else if ((cnt_reg < CNT_W'(3)) || ((cnt_reg == CNT_W'(3)) && dup)) begin
            status_c = STATUS_FEW;
        end else begin
            status_c = STATUS_OK;
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_data  = '{sum_x: sum_reg[0], sum_y: sum_reg[1], sum_z: sum_reg[2],
                       status: status_reg};

    // vertex sequencer: accept, multiply, accumulate, hand off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            close_reg  <= 1'b0;
            acc_en_reg <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        a_reg     <= prev_reg;
                        b_reg     <= cur;
                        last_reg  <= s_data.last_vertex;
                        close_reg <= 1'b0;
                        if (cnt_reg < CNT_W'(MAX_VERTICES)) begin
                            acc_en_reg <= (cnt_reg != '0);
                            prev_reg   <= cur;
                            if (cnt_reg == '0) begin
                                first_reg <= cur;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end else begin
                            acc_en_reg <= 1'b0;
                            ovf_reg    <= 1'b1;
                        end
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    p_reg[0]  <= a_reg[1] * b_reg[2];
                    p_reg[1]  <= a_reg[2] * b_reg[1];
                    p_reg[2]  <= a_reg[2] * b_reg[0];
                    p_reg[3]  <= a_reg[0] * b_reg[2];
                    p_reg[4]  <= a_reg[0] * b_reg[1];
                    p_reg[5]  <= a_reg[1] * b_reg[0];
                    state_reg <= F_ACC;
                end
                F_ACC: begin
                    if (acc_en_reg) begin
                        for (int i = 0; i < 3; i++) begin
                            sum_reg[i] <= sum_reg[i] + term[i];
                        end
                    end
                    if (close_reg) begin
                        state_reg <= F_PUSH;
                    end else if (!last_reg) begin
                        state_reg <= F_IDLE;
                    end else begin
                        status_reg <= status_c;
                        if (status_c == STATUS_OK) begin
                            // closing term last x first
                            a_reg      <= prev_reg;
                            b_reg      <= first_reg;
                            close_reg  <= 1'b1;
                            acc_en_reg <= 1'b1;
                            state_reg  <= F_MUL;
                        end else begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        cnt_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        close_reg <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            sum_reg[i] <= '0;
                        end
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/pa3d_back.sv]
module pa3d_back
    import pa3d_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_empty,
    output logic    q_pop,
    input  job_t    q_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_ADD, B_ROOT, B_OUT} bstate_t;

    bstate_t                  state_reg;
    logic [SUM_BITS-1:0]      mag_reg [3];
    logic [1:0]               comp_reg;
    logic [1:0]               part_reg;
    logic [2*HALF_BITS-1:0]   prod_reg;
    logic [SQ_BITS-1:0]       acc_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [REM_BITS-1:0]      rem_reg;
    logic [5:0]               iter_reg;
    logic [1:0]               status_reg;
    logic [OUT_BITS-1:0]      area_reg;
    logic                     m_valid_reg;
    result_t                  m_data_reg;

    logic [HALF_BITS-1:0]     lo;
    logic [HALF_BITS-1:0]     hi;
    logic [HALF_BITS-1:0]     opa;
    logic [HALF_BITS-1:0]     opb;
    logic [SQ_BITS-1:0]       addend;
    logic [REM_BITS+1:0]      rem_sh;
    logic [REM_BITS+1:0]      trial;
    logic                     ge;
    logic [REM_BITS-1:0]      rem_next;
    logic [ROOT_BITS-1:0]     root_next;
    logic [OUT_BITS-1:0]      area_sat;

    function automatic logic [SUM_BITS-1:0] mag(input logic signed [SUM_BITS-1:0] v);
        return unsigned'(v[SUM_BITS-1] ? -v : v);
    endfunction

    // square of each magnitude from three half-width partial products
    always_comb begin
        lo  = mag_reg[comp_reg][HALF_BITS-1:0];
        hi  = mag_reg[comp_reg][2*HALF_BITS-1:HALF_BITS];
        opa = (part_reg == 2'd0) ? lo : hi;
        opb = (part_reg == 2'd2) ? hi : lo;
        case (part_reg)
            2'd0:    addend = SQ_BITS'(prod_reg);
            2'd1:    addend = SQ_BITS'(prod_reg) << (HALF_BITS + 1);
            default: addend = SQ_BITS'(prod_reg) << (2 * HALF_BITS);
        endcase
    end

    // one restoring square root step: two radicand bits per cycle
    always_comb begin
        rem_sh    = {rem_reg, acc_reg[SQ_BITS-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
        root_next = {root_reg[ROOT_BITS-2:0], ge};
        area_sat  = (root_next[ROOT_BITS-1:OUT_BITS] != '0) ? '1
                                                            : root_next[OUT_BITS-1:0];
    end

    assign q_pop   = (state_reg == B_IDLE) && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            comp_reg    <= '0;
            part_reg    <= '0;
            iter_reg    <= '0;
        end else begin
            // word taken; B_OUT reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != B_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        mag_reg[0] <= mag(q_data.sum_x);
                        mag_reg[1] <= mag(q_data.sum_y);
                        mag_reg[2] <= mag(q_data.sum_z);
                        status_reg <= q_data.status;
                        acc_reg    <= '0;
                        comp_reg   <= '0;
                        part_reg   <= '0;
                        if (q_data.status != STATUS_OK) begin
                            area_reg  <= '0;
                            state_reg <= B_OUT;
                        end else begin
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    prod_reg  <= opa * opb;
                    state_reg <= B_ADD;
                end
                B_ADD: begin
                    acc_reg <= acc_reg + addend;
                    if (part_reg == 2'd2) begin
                        part_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            root_reg  <= '0;
                            rem_reg   <= '0;
                            iter_reg  <= 6'(ROOT_BITS - 1);
                            state_reg <= B_ROOT;
                        end else begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= B_MUL;
                        end
                    end else begin
                        part_reg  <= part_reg + 1'b1;
                        state_reg <= B_MUL;
                    end
                end
                B_ROOT: begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    acc_reg  <= acc_reg << 2;
                    if (iter_reg == '0) begin
                        area_reg  <= area_sat;
                        state_reg <= B_OUT;
                    end else begin
                        iter_reg <= iter_reg - 1'b1;
                    end
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= '{twice_area: area_reg, status: status_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/polygon_area_3d.sv]
// Vertex side: each vertex word passes the accept, multiply and accumulate states before the next is taken;
// the last vertex adds a multiply and accumulate for the closing term and a push to queue the polygon.
// Result side: the back end loads a polygon, builds the squares from partial products,
// runs 46 square root steps and outputs the word; a 2-deep queue lets both sides run apart.
// A polygon with an error status skips the closing term, the squares and the square root.
// Reset (aresetn, synchronous, active low) clears sums, counts, queue and output valid.
module polygon_area_3d
    import pa3d_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  vertex_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t q_wdata;
    job_t q_rdata;

    // front: vertex accumulation
    pa3d_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_data  (q_wdata)
    );

    // polygon queue
    pa3d_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // back: length of the cross vector
    pa3d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("polygon queue written while full");

    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("polygon queue read while empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |-> (m_data.twice_area == '0))
        else $error("error status word carries a nonzero area");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= STATUS_OVF))
        else $error("undefined status code on result");

endmodule

[test/tb_polygon_area_3d.sv]
module tb_polygon_area_3d;
    import pa3d_pkg::*;

    localparam int MAX_VERTS     = 1024;
    localparam int RANDOM_ITEMS  = 150;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [42:0] AREA_MAX = 43'h7FF_FFFF_FFFF;

    // One directed vertex word; res is used only where typed is set
    typedef struct packed {
        vertex_t v;
        logic    typed;
        result_t res;
    } stim_row_t;

    localparam int N_DIRECTED = 21;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // lone vertex right after reset, most negative corner
        '{'{16'h8000, 16'h8000, 16'h8000, 1'b1}, 1'b1, '{43'd0, STATUS_FEW}},
        // two vertices only
        '{'{16'h7fff, 16'h7fff, 16'h7fff, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h8000, 16'h0000, 16'h7fff, 1'b1}, 1'b1, '{43'd0, STATUS_FEW}},
        // triangle closed on its first vertex leaves two distinct points
        '{'{16'sd5, 16'sd6, 16'sd7, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd1, 16'sd2, 16'sd3, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd5, 16'sd6, 16'sd7, 1'b1}, 1'b1, '{43'd0, STATUS_FEW}},
        // square with repeated closing vertex
        '{'{16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd10, 16'sd0, 16'sd0, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd10, 16'sd10, 16'sd0, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd0, 16'sd10, 16'sd0, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b0, '{43'd0, STATUS_OK}},
        // extreme-corner triangle
        '{'{16'h8000, 16'h8000, 16'h8000, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h7fff, 16'h8000, 16'h7fff, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h8000, 16'h7fff, 16'h7fff, 1'b1}, 1'b0, '{43'd0, STATUS_OK}},
        // triangle on the positive axes
        '{'{16'h7fff, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h0000, 16'h7fff, 16'h0000, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h0000, 16'h0000, 16'h7fff, 1'b1}, 1'b0, '{43'd0, STATUS_OK}},
        // mixed-sign quad
        '{'{16'h8000, 16'h7fff, 16'hffff, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h7fff, 16'h8000, 16'h0000, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'h0001, 16'h0001, 16'h8000, 1'b0}, 1'b0, '{43'd0, STATUS_OK}},
        '{'{16'hffff, 16'hffff, 16'h7fff, 1'b1}, 1'b0, '{43'd0, STATUS_OK}}
    };

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    vertex_t s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    polygon_area_3d uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Area predictor state
    vertex_t            poly_first;
    vertex_t            poly_prev;
    logic signed [43:0] cross_x, cross_y, cross_z;
    int unsigned        poly_count;
    bit                 poly_overflow;

    result_t pending_areas [$];
    int      mismatches   = 0;
    int      vertices_sent = 0;
    int      burst_left   = 0;
    bit      steady       = 1'b0;

    function automatic void clear_polygon();
        poly_first    = '0;
        poly_prev     = '0;
        cross_x       = '0;
        cross_y       = '0;
        cross_z       = '0;
        poly_count    = 0;
        poly_overflow = 1'b0;
    endfunction

    // Add a x b to the summed cross vector, wrapping at 44 bits
    function automatic void fold_edge(vertex_t a, vertex_t b);
        longint tx, ty, tz;
        tx = longint'(a.vy) * b.vz - longint'(a.vz) * b.vy;
        ty = longint'(a.vz) * b.vx - longint'(a.vx) * b.vz;
        tz = longint'(a.vx) * b.vy - longint'(a.vy) * b.vx;
        cross_x = cross_x + 44'(tx);
        cross_y = cross_y + 44'(ty);
        cross_z = cross_z + 44'(tz);
    endfunction

    function automatic logic [63:0] magnitude(logic signed [43:0] s);
        longint w;
        w = s;
        return (w < 0) ? -w : w;
    endfunction

    // Bitwise floor square root, saturated to the result width
    function automatic logic [42:0] floor_root(logic [127:0] n);
        logic [63:0] r, c;
        r = '0;
        for (int b = 45; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n)
                r = c;
        end
        return (r > 64'(AREA_MAX)) ? AREA_MAX : r[42:0];
    endfunction

    // Feed one vertex; returns 1 with the expected word when a polygon closes
    function automatic bit area_step(input vertex_t v, output result_t r);
        int unsigned  distinct;
        logic [63:0]  mx, my, mz;
        logic [127:0] sq;
        r = '0;
        if (poly_count < MAX_VERTS) begin
            if (poly_count == 0)
                poly_first = v;
            else
                fold_edge(poly_prev, v);
            poly_prev  = v;
            poly_count = poly_count + 1;
        end else begin
            poly_overflow = 1'b1;
        end
        if (!v.last_vertex)
            return 1'b0;

        // a closing vertex equal to the first is not a new corner
        distinct = poly_count;
        if (distinct >= 2 && poly_prev.vx == poly_first.vx &&
            poly_prev.vy == poly_first.vy && poly_prev.vz == poly_first.vz)
            distinct = distinct - 1;

        if (poly_overflow) begin
            r.status = STATUS_OVF;
        end else if (distinct < 3) begin
            r.status = STATUS_FEW;
        end else begin
            fold_edge(poly_prev, poly_first);
            mx = magnitude(cross_x);
            my = magnitude(cross_y);
            mz = magnitude(cross_z);
            sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
            r.twice_area = floor_root(sq);
            r.status     = STATUS_OK;
        end
        clear_polygon();
        return 1'b1;
    endfunction

    // Sender bursts: random length, random gap before each burst unless steady is set
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
    endtask

    // Present one vertex word, hold until taken, then log its expectation
    task automatic send_vertex(input vertex_t v, input bit typed, input result_t typed_res);
        result_t predicted;
        bit      closes;
        s_data  <= v;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        vertices_sent = vertices_sent + 1;
        closes = area_step(v, predicted);
        if (closes)
            pending_areas.push_back(typed ? typed_res : predicted);
    endtask

    // Hold the sender off until every expected result word is out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_areas.size() != 0) @(posedge aclk);
    endtask

    // mode 0: full range, 1: tiny range (coincident points), else extremes only
    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 8) - 4);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic send_polygon(int n_verts, int mode, bit close_on_first);
        vertex_t first, v;
        for (int i = 0; i < n_verts; i++) begin
            if (close_on_first && i > 0 && i == n_verts - 1)
                v = first;
            else
                v = {rand_coord(mode), rand_coord(mode), rand_coord(mode), 1'b0};
            v.last_vertex = (i == n_verts - 1);
            if (i == 0)
                first = v;
            pace();
            send_vertex(v, 1'b0, '0);
        end
    endtask

    // Receiver: calm stretches, then random stalls of random length
    int cyc        = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (cyc[10:9] != 2'd0 && $urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 40);
        end
    end

    // Result checker
    result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_areas.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result word: area=%0d status=%0d",
                             m_data.twice_area, m_data.status);
            end else begin
                want = pending_areas.pop_front();
                if (m_data.twice_area !== want.twice_area || m_data.status !== want.status) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: want area=%0d status=%0d, got area=%0d status=%0d",
                                 want.twice_area, want.status,
                                 m_data.twice_area, m_data.status);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving either way
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int  kind, n_verts, mode;
        bit  close_on_first;
        clear_polygon();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            pace();
            send_vertex(DIRECTED[i].v, DIRECTED[i].typed, DIRECTED[i].res);
        end
        wait_drained();

        // random polygons: mostly well formed, some short, some noise
        while (vertices_sent < N_DIRECTED + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                n_verts        = $urandom_range(3, 10);
                mode           = $urandom_range(0, 2);
                close_on_first = ($urandom_range(0, 3) == 0);
            end else if (kind < 17) begin
                n_verts        = $urandom_range(1, 3);
                mode           = 1;
                close_on_first = ($urandom_range(0, 1) == 1);
            end else begin
                n_verts        = $urandom_range(1, 16);
                mode           = $urandom_range(0, 2);
                close_on_first = 1'b0;
            end
            steady = ($urandom_range(0, 4) == 0);
            send_polygon(n_verts, mode, close_on_first);
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end

        // vertex limit: full, then a closing repeat that no longer fits
        steady = 1'b0;
        send_polygon(MAX_VERTS + 1, 2, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_areas.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/pa3d_pkg.sv
rtl/pa3d_fifo.sv
rtl/pa3d_front.sv
rtl/pa3d_back.sv
rtl/polygon_area_3d.sv
test/tb_polygon_area_3d.sv
